FILE: sv/csad_pkg.sv
`default_nettype none
package csad_pkg;

    localparam int NUM_STAGES = 64;
    localparam int NUM_ROUNDS = 56;
    localparam int INIT_CLKS  = 32;

    localparam logic REG_CB0 = 1'b0;
    localparam logic REG_CB1 = 1'b1;

    localparam logic [63:0] BYTE_REP = 64'h0101010101010101;
    localparam logic [63:0] HI_NIB   = 64'hf0f0f0f0f0f0f0f0;
    localparam logic [63:0] LO_NIB   = 64'h0f0f0f0f0f0f0f0f;

    typedef struct packed {
        logic [39:0] ra;
        logic [39:0] rb;
        logic [3:0]  e;
        logic [3:0]  f;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [3:0]  d;
        logic        c;
        logic        p;
        logic        q;
        logic [63:0] ks;
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] key;
    } csad_st_t;

    localparam logic [1:0] SSB [0:6][0:31] = '{
        '{2,0,1,1,2,3,3,0,3,2,2,0,1,1,0,3, 0,3,3,0,2,2,1,1,2,2,0,3,1,1,3,0},
        '{3,1,0,2,2,3,3,0,1,3,2,1,0,0,1,2, 3,1,0,3,3,2,0,2,0,0,1,2,2,1,3,1},
        '{2,0,1,2,2,3,3,1,1,1,0,3,3,0,2,0, 1,3,0,1,3,0,2,2,2,0,1,2,0,3,3,1},
        '{3,1,2,3,0,2,1,2,1,2,0,1,3,0,0,3, 1,0,3,1,2,3,0,3,0,3,2,0,1,2,2,1},
        '{2,0,0,1,3,2,3,2,0,1,3,3,1,0,2,1, 2,3,2,0,0,3,1,1,1,0,3,2,3,1,0,2},
        '{0,1,2,3,1,2,2,0,0,1,3,0,2,3,1,3, 2,3,0,2,3,0,1,1,2,1,1,2,0,3,3,0},
        '{0,3,2,2,3,0,0,1,3,0,1,3,1,2,2,1, 1,0,3,3,0,1,1,2,2,3,1,0,2,3,0,2}
    };

    localparam int SSB_TAP [0:6][0:4] = '{
        '{12,2,21,27,32}, '{5,10,23,24,33}, '{3,4,17,19,22}, '{11,1,7,14,28},
        '{18,15,20,29,34}, '{9,13,16,26,35}, '{6,8,25,30,31}
    };

    localparam int BTAP [0:3][0:3] = '{
        '{8,21,26,35}, '{20,29,11,14}, '{19,30,12,17}, '{34,23,9,28}
    };

    localparam logic [7:0] BSUB [0:255] = '{
        8'h3a,8'hea,8'h68,8'hfe,8'h33,8'he9,8'h88,8'h1a,
        8'h83,8'hcf,8'he1,8'h7f,8'hba,8'he2,8'h38,8'h12,
        8'he8,8'h27,8'h61,8'h95,8'h0c,8'h36,8'he5,8'h70,
        8'ha2,8'h06,8'h82,8'h7c,8'h17,8'ha3,8'h26,8'h49,
        8'hbe,8'h7a,8'h6d,8'h47,8'hc1,8'h51,8'h8f,8'hf3,
        8'hcc,8'h5b,8'h67,8'hbd,8'hcd,8'h18,8'h08,8'hc9,
        8'hff,8'h69,8'hef,8'h03,8'h4e,8'h48,8'h4a,8'h84,
        8'h3f,8'hb4,8'h10,8'h04,8'hdc,8'hf5,8'h5c,8'hc6,
        8'h16,8'hab,8'hac,8'h4c,8'hf1,8'h6a,8'h2f,8'h3c,
        8'h3b,8'hd4,8'hd5,8'h94,8'hd0,8'hc4,8'h63,8'h62,
        8'h71,8'ha1,8'hf9,8'h4f,8'h2e,8'haa,8'hc5,8'h56,
        8'he3,8'h39,8'h93,8'hce,8'h65,8'h64,8'he4,8'h58,
        8'h6c,8'h19,8'h42,8'h79,8'hdd,8'hee,8'h96,8'hf6,
        8'h8a,8'hec,8'h1e,8'h85,8'h53,8'h45,8'hde,8'hbb,
        8'h7e,8'h0a,8'h9a,8'h13,8'h2a,8'h9d,8'hc2,8'h5e,
        8'h5a,8'h1f,8'h32,8'h35,8'h9c,8'ha8,8'h73,8'h30,
        8'h29,8'h3d,8'he7,8'h92,8'h87,8'h1b,8'h2b,8'h4b,
        8'ha5,8'h57,8'h97,8'h40,8'h15,8'he6,8'hbc,8'h0e,
        8'heb,8'hc3,8'h34,8'h2d,8'hb8,8'h44,8'h25,8'ha4,
        8'h1c,8'hc7,8'h23,8'hed,8'h90,8'h6e,8'h50,8'h00,
        8'h99,8'h9e,8'h4d,8'hd9,8'hda,8'h8d,8'h6f,8'h5f,
        8'h3e,8'hd7,8'h21,8'h74,8'h86,8'hdf,8'h6b,8'h05,
        8'h8e,8'h5d,8'h37,8'h11,8'hd2,8'h28,8'h75,8'hd6,
        8'ha7,8'h77,8'h24,8'hbf,8'hf0,8'hb0,8'h02,8'hb7,
        8'hf8,8'hfc,8'h81,8'h09,8'hb1,8'h01,8'h76,8'h91,
        8'h7d,8'h0f,8'hc8,8'ha0,8'hf2,8'hcb,8'h78,8'h60,
        8'hd1,8'hf7,8'he0,8'hb5,8'h98,8'h22,8'hb3,8'h20,
        8'h1d,8'ha6,8'hdb,8'h7b,8'h59,8'h9f,8'hae,8'h31,
        8'hfb,8'hd3,8'hb6,8'hca,8'h43,8'h72,8'h07,8'hf4,
        8'hd8,8'h41,8'h14,8'h55,8'h0d,8'h54,8'h8b,8'hb9,
        8'had,8'h46,8'h0b,8'haf,8'h80,8'h52,8'h2c,8'hfa,
        8'h8c,8'h89,8'h66,8'hfd,8'hb2,8'ha9,8'h9b,8'hc0
    };

    localparam int KPERM [0:63] = '{
        19,27,55,46,1,15,36,22, 56,61,39,21,54,58,50,28,
        7,29,51,6,33,35,20,16, 47,30,32,63,10,11,4,38,
        62,26,40,18,12,52,37,53, 23,59,41,17,31,0,25,43,
        44,14,2,13,45,48,3,60, 49,8,34,5,9,42,57,24
    };

    localparam int RPERM [0:7] = '{1,7,5,4,2,6,0,3};

    function automatic logic [63:0] key_perm(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            r[KPERM[i]] = v[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] round_perm(input logic [7:0] v);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[RPERM[i]] = v[i];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/csad_stage.sv
`default_nettype none
module csad_stage #(
    parameter int STAGE = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              vld_in,
    input  wire csad_pkg::csad_st_t st_in,
    input  wire logic [63:0]       cb0,
    output logic                   vld_out,
    output csad_pkg::csad_st_t     st_out
);
    import csad_pkg::*;

    localparam bit IS_INIT   = (STAGE < INIT_CLKS);
    localparam bit HAS_ROUND = (STAGE < NUM_ROUNDS);
    localparam int BYTE_IDX  = IS_INIT ? (7 - STAGE / 4) : 0;
    localparam bit USE_HI    = ((STAGE % 2) == 0);
    localparam int RND       = HAS_ROUND ? (NUM_ROUNDS - 1 - STAGE) : 0;
    localparam int SCH_BYTE  = RND % 8;
    localparam logic [7:0] SCH_CONST = 8'(RND / 8);
    localparam bit DO_PERM   = HAS_ROUND && ((RND % 8) == 0);
    localparam int KS_POS    = IS_INIT ? 1 : (63 - 2 * (STAGE - INIT_CLKS));

    logic               vld_reg;
    csad_st_t           st_reg;
    csad_st_t           st_next;
    logic [7:0]         by;
    logic [3:0]         ia, ib, bo, a0, b0, d_new;
    logic [4:0]         sum;
    logic [4:0]         addr;
    logic [1:0]         s [0:6];
    logic [7:0]         w [0:7];
    logic [7:0]         sb, l;

    always_comb begin
        st_next = st_in;
        by = cb0[8*BYTE_IDX +: 8];
        ia = USE_HI ? by[7:4] : by[3:0];
        ib = USE_HI ? by[3:0] : by[7:4];
        for (int i = 0; i < 4; i++) begin
            bo[3-i] = st_in.rb[BTAP[i][0]] ^ st_in.rb[BTAP[i][1]]
                    ^ st_in.rb[BTAP[i][2]] ^ st_in.rb[BTAP[i][3]];
        end
        a0 = st_in.ra[39:36] ^ st_in.x;
        b0 = st_in.rb[27:24] ^ st_in.rb[39:36] ^ st_in.y;
        if (IS_INIT) begin
            a0 = a0 ^ st_in.d ^ ia;
            b0 = b0 ^ ib;
        end
        d_new = st_in.e ^ st_in.z ^ bo;
        st_next.d = d_new;
        if (!IS_INIT) begin
            st_next.ks[KS_POS]   = d_new[3] ^ d_new[2];
            st_next.ks[KS_POS-1] = d_new[0] ^ d_new[1];
        end
        if (st_in.p) begin
            b0 = {b0[2:0], b0[3]};
        end
        sum = 5'(st_in.e) + 5'(st_in.z) + 5'(st_in.c);
        if (!st_in.q) begin
            st_next.e = st_in.f;
            st_next.f = st_in.e;
        end else begin
            st_next.e = st_in.f;
            st_next.f = sum[3:0];
            st_next.c = sum[4];
        end
        for (int i = 0; i < 7; i++) begin
            addr = '0;
            for (int j = 0; j < 5; j++) begin
                addr[4-j] = st_in.ra[SSB_TAP[i][j]];
            end
            s[i] = SSB[i][addr];
        end
        st_next.x = {s[3][0], s[2][0], s[1][1], s[0][1]};
        st_next.y = {s[5][0], s[4][0], s[3][1], s[2][1]};
        st_next.z = {s[1][0], s[0][0], s[5][1], s[4][1]};
        st_next.p = s[6][1];
        st_next.q = s[6][0];
        st_next.ra = {st_in.ra[35:0], a0};
        st_next.rb = {st_in.rb[35:0], b0};

        // one block cipher round while rounds remain
        for (int i = 0; i < 8; i++) begin
            w[i] = st_in.w[63-8*i -: 8];
        end
        sb = BSUB[st_in.t[8*SCH_BYTE +: 8] ^ SCH_CONST ^ w[6]];
        l  = w[7] ^ sb;
        if (HAS_ROUND) begin
            st_next.w = {l, w[0], w[1] ^ l, w[2] ^ l, w[3] ^ l, w[4],
                         w[5] ^ round_perm(sb), w[6]};
        end
        if (DO_PERM) begin
            st_next.t = key_perm(st_in.t);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign vld_out = vld_reg;
    assign st_out  = st_reg;

endmodule
`default_nettype wire

FILE: sv/csa_first_block_descrambler.sv
`default_nettype none
// channel   handshake            payload
// input     s_valid / s_ready    s_candidate_key
// result    m_valid / m_ready    m_plain_block, m_key_echo
// config    cfg_we               cfg_idx, cfg_data
//
// one candidate key per cycle while the result side is not stalled; 64 stages
// of one stream cipher step each (the first 56 also carry one block cipher
// round) plus the output register
// aresetn clears the stage valid bits, the output valid and both cipher blocks
// a stalled result freezes every stage together, nothing is dropped
module csa_first_block_descrambler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_candidate_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_plain_block,
    output logic [63:0]      m_key_echo,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [63:0] cfg_data
);
    import csad_pkg::*;

    logic [63:0] cb0_reg, cb1_reg;
    logic        out_vld_reg;
    logic [63:0] plain_reg, echo_reg;
    logic        adv;
    logic [NUM_STAGES:0] vld;
    csad_st_t    st [0:NUM_STAGES];
    logic [63:0] sw;

    assign adv = !out_vld_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb0_reg <= '0;
            cb1_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_CB0: cb0_reg <= cfg_data;
                REG_CB1: cb1_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sw = ((s_candidate_key & HI_NIB) >> 4) | ((s_candidate_key & LO_NIB) << 4);

    always_comb begin
        st[0] = '0;
        st[0].ra  = {8'h00, sw[31:0]};
        st[0].rb  = {8'h00, sw[63:32]};
        st[0].w   = cb0_reg;
        st[0].t   = s_candidate_key;
        st[0].key = s_candidate_key;
    end
    assign vld[0] = s_valid;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        csad_stage #(.STAGE(g)) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_in  (vld[g]),
            .st_in   (st[g]),
            .cb0     (cb0_reg),
            .vld_out (vld[g+1]),
            .st_out  (st[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld[NUM_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            plain_reg <= cb1_reg ^ st[NUM_STAGES].ks ^ st[NUM_STAGES].w;
            echo_reg  <= st[NUM_STAGES].key;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_plain_block = plain_reg;
    assign m_key_echo    = echo_reg;

`ifndef SYNTHESIS
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld[NUM_STAGES:1]))
        else $error("pipeline moved during stall");
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld[NUM_STAGES]))
        else $error("result without a finished item");
    a_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld[NUM_STAGES] |=> m_key_echo == $past(st[NUM_STAGES].key))
        else $error("key echo mismatch");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/csad_checker.sv
module csad_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [63:0] s_candidate_key,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_plain_block,
    input  wire logic [63:0] m_key_echo,
    input  wire logic        cfg_we,
    input  wire logic        cfg_idx,
    input  wire logic [63:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    import csad_pkg::*;

    logic [63:0] cb0, cb1;
    logic [63:0] plain_q[$];
    logic [63:0] key_q[$];

    function automatic logic [63:0] schedule_perm(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[KPERM[i]] = v[i];
        return r;
    endfunction

    function automatic logic [7:0] byte_perm(input logic [7:0] v);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) r[RPERM[i]] = v[i];
        return r;
    endfunction

    function automatic logic [63:0] decrypt_block(input logic [63:0] cb, input logic [63:0] key);
        logic [7:0] sched [0:55];
        logic [7:0] w [0:7];
        logic [63:0] t, k, r;
        logic [7:0] s, l;
        t = key;
        for (int i = 6; i >= 0; i--) begin
            k = t ^ (BYTE_REP * i);
            for (int j = 0; j < 8; j++) sched[i*8+j] = k[j*8 +: 8];
            t = schedule_perm(t);
        end
        for (int i = 0; i < 8; i++) w[i] = cb[(7-i)*8 +: 8];
        for (int i = 55; i >= 0; i--) begin
            s = BSUB[sched[i] ^ w[6]];
            l = w[7] ^ s;
            w[7] = w[6];
            w[6] = w[5] ^ byte_perm(s);
            w[5] = w[4];
            w[4] = w[3] ^ l;
            w[3] = w[2] ^ l;
            w[2] = w[1] ^ l;
            w[1] = w[0];
            w[0] = l;
        end
        r = '0;
        for (int i = 0; i < 8; i++) r[(7-i)*8 +: 8] = w[i];
        return r;
    endfunction

    function automatic logic [63:0] stream_bits(input logic [63:0] cb, input logic [63:0] skey);
        logic [39:0] ra, rb;
        logic [63:0] ks;
        logic [3:0] e, f, x, y, z, d, ia, ib, a0, b0, bo, tn;
        logic [4:0] sum, addr;
        logic c, p, q;
        logic [1:0] s [0:6];
        logic [7:0] by;
        ra = {8'h0, skey[31:0]};
        rb = {8'h0, skey[63:32]};
        ks = '0;
        {e, f, x, y, z, d, ia, ib} = '0;
        {c, p, q} = '0;
        for (int clk = 0; clk < 64; clk++) begin
            for (int i = 0; i < 4; i++)
                bo[3-i] = rb[BTAP[i][0]] ^ rb[BTAP[i][1]] ^ rb[BTAP[i][2]] ^ rb[BTAP[i][3]];
            if (clk < 32) begin
                if ((clk & 3) == 0) begin
                    by = cb[8*(7-clk/4) +: 8];
                    ib = by[3:0];
                    ia = by[7:4];
                end
                a0 = ra[39:36] ^ x ^ d ^ ia;
                b0 = rb[27:24] ^ rb[39:36] ^ y ^ ib;
                tn = ia; ia = ib; ib = tn;
                d = e ^ z ^ bo;
            end else begin
                a0 = ra[39:36] ^ x;
                b0 = rb[27:24] ^ rb[39:36] ^ y;
                d = e ^ z ^ bo;
                ks = {ks[61:0], d[3] ^ d[2], d[0] ^ d[1]};
            end
            if (p) b0 = {b0[2:0], b0[3]};
            if (!q) begin
                tn = e; e = f; f = tn;
            end else begin
                sum = e + z + c;
                e = f;
                f = sum[3:0];
                c = sum[4];
            end
            for (int i = 0; i < 7; i++) begin
                for (int j = 0; j < 5; j++) addr[4-j] = ra[SSB_TAP[i][j]];
                s[i] = SSB[i][addr];
            end
            x = {s[3][0], s[2][0], s[1][1], s[0][1]};
            y = {s[5][0], s[4][0], s[3][1], s[2][1]};
            z = {s[1][0], s[0][0], s[5][1], s[4][1]};
            p = s[6][1];
            q = s[6][0];
            ra = {ra[35:0], a0};
            rb = {rb[35:0], b0};
        end
        return ks;
    endfunction

    assign pending = plain_q.size();

    always @(posedge aclk) begin
        logic [63:0] sw, exp_plain, exp_key;
        int errs;
        errs = 0;
        if (!aresetn) begin
            cb0 <= '0;
            cb1 <= '0;
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == REG_CB0) cb0 <= cfg_data;
                else cb1 <= cfg_data;
            end
            if (s_valid && s_ready) begin
                sw = ((s_candidate_key & HI_NIB) >> 4) | ((s_candidate_key & LO_NIB) << 4);
                plain_q.push_back(cb1 ^ stream_bits(cb0, sw) ^ decrypt_block(cb0, s_candidate_key));
                key_q.push_back(s_candidate_key);
            end
            if (m_valid && m_ready) begin
                if (plain_q.size() == 0) begin
                    $error("unexpected result transfer: plain_block %h", m_plain_block);
                    errs++;
                end else begin
                    exp_plain = plain_q.pop_front();
                    exp_key = key_q.pop_front();
                    if (m_plain_block !== exp_plain) begin
                        $error("plain_block expected %h actual %h", exp_plain, m_plain_block);
                        errs++;
                    end
                    if (m_key_echo !== exp_key) begin
                        $error("key_echo expected %h actual %h", exp_key, m_key_echo);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

FILE: tb/sv/csa_first_block_descrambler_tb.sv
module csa_first_block_descrambler_tb;
    import csad_pkg::*;

    localparam int WATCHDOG = 2000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [63:0] s_candidate_key = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_plain_block, m_key_echo;
    logic        cfg_we = 0;
    logic        cfg_idx = REG_CB0;
    logic [63:0] cfg_data = '0;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          stim_done = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    csa_first_block_descrambler uut (.*);

    csad_checker chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("csa_first_block_descrambler: mismatch");
            $finish;
        end
    end

    // result side stalls at random between results, and often does not stall at all
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic send_key(input logic [63:0] key, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_candidate_key <= key;
        @(posedge aclk iff s_ready);
    endtask

    task automatic write_block(input logic idx, input logic [63:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_keys(input int count);
        bit burst;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) burst = $urandom_range(0, 3) == 0;
            send_key({$urandom, $urandom}, burst);
        end
    endtask

    initial begin
        logic [63:0] directed [] = '{64'h0, 64'hffffffffffffffff, 64'h0123456789abcdef,
            64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h8000000000000001,
            64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 64'h0000000100000000};
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // blocks at reset value
        foreach (directed[i]) send_key(directed[i], 0);
        drain();
        write_block(REG_CB0, 64'hffffffffffffffff);
        write_block(REG_CB1, 64'hffffffffffffffff);
        foreach (directed[i]) send_key(directed[i], 0);
        drain();
        write_block(REG_CB0, 64'h0011223344556677);
        write_block(REG_CB1, 64'h8899aabbccddeeff);
        foreach (directed[i]) send_key(directed[i], 1);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_block(REG_CB0, {$urandom, $urandom});
            write_block(REG_CB1, {$urandom, $urandom});
            random_keys(190);
            drain();
        end
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("csa_first_block_descrambler: match");
        end else begin
            $display("csa_first_block_descrambler: mismatch");
        end
        $finish;
    end
endmodule
